FILE: src/u8d_pkg.sv
// u8d_pkg: shared widths, status codes and constants for the utf-8 stream decoder
// no dependencies; imported by utf8_stream_decoder_top and its testbench
`default_nettype none

package u8d_pkg;

    localparam int unsigned ByteW    = 8;
    localparam int unsigned CpW      = 21;
    localparam int unsigned StatusW  = 2;
    localparam int unsigned PendW    = 2;
    localparam int unsigned ContBits = 6;

    typedef logic [ByteW-1:0]   byte_t;
    typedef logic [CpW-1:0]     cp_t;
    typedef logic [PendW-1:0]   pend_t;

    typedef enum logic [StatusW-1:0] {
        ST_VALID   = 2'd0,
        ST_INVALID = 2'd1,
        ST_BROKEN  = 2'd2
    } status_t;

    localparam cp_t Replacement = cp_t'(21'h00FFFD);

endpackage : u8d_pkg

`default_nettype wire

FILE: src/utf8_stream_decoder_top.sv
// utf8_stream_decoder_top: streaming utf-8 decoder, one byte per clock unless stalled
// depends on u8d_pkg for widths, status codes and the replacement code point
//
// usage:
//   input channel in_valid/in_ready carries one raw byte (in_byte) per transfer.
//   output channel out_valid/out_ready carries one decoded result
//   (code_point, status) per transfer; multi-byte lead bytes and continuation
//   bytes that do not finish a pending sequence give no result.
//   path: a byte is held in the input register, and the result that it completes
//   is held in the result register before it reaches the output.
//   throughput: one byte per cycle while in_ready stays high (see stall); set by
//   the single decode step between the input register and the result register.
//   stall: while out_ready is low and a result waits, a byte that gives no
//   result still moves through; a byte that gives a result waits in the
//   input register, and in_ready drops only when that register cannot drain.
//   reset (rst_n low, asynchronous): both registers empty, partial value and
//   pending count cleared, so decoding restarts at a lead byte.
`default_nettype none

module utf8_stream_decoder_top
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire u8d_pkg::byte_t         in_byte,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output u8d_pkg::cp_t                code_point,
    output logic [u8d_pkg::StatusW-1:0] status
);
    import u8d_pkg::*;

    logic    byte_valid_reg;
    byte_t   byte_reg;
    cp_t     partial_reg,  partial_next;
    pend_t   pending_reg,  pending_next;
    logic    out_valid_reg;
    cp_t     cp_reg,       cp_next;
    status_t status_reg,   status_next;

    logic    has_result;
    logic    out_free;
    logic    s1_fire;
    cp_t     shifted;

    assign shifted = cp_t'({partial_reg, byte_reg[ContBits-1:0]});

    // decode step on the registered byte
    always_comb
    begin
        has_result   = 1'b0;
        partial_next = partial_reg;
        pending_next = pending_reg;
        cp_next      = '0;
        status_next  = ST_VALID;
        if (pending_reg != '0)
        begin
            if (!byte_reg[7])
            begin
                // broken sequence: byte is swallowed
                has_result   = 1'b1;
                partial_next = '0;
                pending_next = '0;
                status_next  = ST_BROKEN;
            end
            else if (pending_reg == pend_t'(1))
            begin
                has_result   = 1'b1;
                cp_next      = shifted;
                partial_next = '0;
                pending_next = '0;
            end
            else
            begin
                partial_next = shifted;
                pending_next = pending_reg - pend_t'(1);
            end
        end
        else
        begin
            casez (byte_reg)
                8'b0???????:
                begin
                    has_result = 1'b1;
                    cp_next    = cp_t'(byte_reg[6:0]);
                end
                8'b10??????:
                begin
                    has_result = 1'b1;
                    cp_next    = cp_t'(byte_reg[5:0]);
                end
                8'b110?????:
                begin
                    partial_next = cp_t'(byte_reg[4:0]);
                    pending_next = pend_t'(1);
                end
                8'b1110????:
                begin
                    partial_next = cp_t'(byte_reg[3:0]);
                    pending_next = pend_t'(2);
                end
                8'b11110???:
                begin
                    partial_next = cp_t'(byte_reg[2:0]);
                    pending_next = pend_t'(3);
                end
                default:
                begin
                    // more than four leading ones
                    has_result  = 1'b1;
                    cp_next     = Replacement;
                    status_next = ST_INVALID;
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = byte_valid_reg && (!has_result || out_free);
    assign in_ready = !byte_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            partial_reg    <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                partial_reg <= partial_next;
                pending_reg <= pending_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_fire && has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
        if (out_free && s1_fire && has_result)
        begin
            cp_reg     <= cp_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = cp_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    a_idle_partial_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == '0 |-> partial_reg == '0)
        else $error("partial value left over with no bytes pending");

    a_invalid_is_repl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_INVALID |-> cp_reg == Replacement)
        else $error("invalid lead without replacement code point");

    a_broken_is_null: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_BROKEN |-> cp_reg == '0)
        else $error("broken sequence with nonzero code point");

    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid_reg && !s1_fire |=> byte_valid_reg && $stable(byte_reg))
        else $error("input register lost a byte while stalled");
`endif

endmodule : utf8_stream_decoder_top

`default_nettype wire

FILE: dv/tb_utf8_stream_decoder_top.sv
// tb_utf8_stream_decoder_top: self-checking testbench for the utf-8 stream decoder
// drives raw bytes through the input channel, predicts each decoded result and checks it
// depends on u8d_pkg and utf8_stream_decoder_top
`default_nettype none

module tb_utf8_stream_decoder_top;

    timeunit 1ns;
    timeprecision 1ps;

    import u8d_pkg::*;

    typedef struct {
        byte_t data;
        int    gap;
        bit    drain;
    } byte_item_t;

    typedef struct {
        cp_t     cp;
        status_t st;
    } decoded_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    byte_t               in_byte   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    cp_t                 code_point;
    logic [StatusW-1:0]  status;

    byte_item_t byte_q[$];
    decoded_t   decoded_q[$];

    // predictor state
    cp_t   acc_value = '0;
    pend_t cont_left = '0;

    // handshake flags sampled at the rising edge
    bit in_taken  = 1'b0;
    bit out_taken = 1'b0;

    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit rx_hold_req = 1'b0;
    int tx_wait     = 0;
    int cur_gap     = 0;
    int rx_wait     = 0;
    int hold_left   = 0;
    int queued_cnt  = 0;
    int err_cnt     = 0;

    byte_item_t tx_item;
    logic       has_res;
    decoded_t   exp_res;
    decoded_t   got_res;

    utf8_stream_decoder_top uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .status     (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // one decode step; updates the predictor state
    function automatic void decode_byte(input byte_t b, output logic produced,
                                        output decoded_t res);
        int ones;
        produced = 1'b0;
        res.cp   = '0;
        res.st   = ST_VALID;
        ones     = 0;
        if (cont_left != 0)
        begin
            if (!b[7])
            begin
                // broken sequence, the byte is swallowed
                acc_value = '0;
                cont_left = '0;
                produced  = 1'b1;
                res.st    = ST_BROKEN;
            end
            else
            begin
                acc_value = cp_t'({acc_value, b[ContBits-1:0]});
                cont_left = cont_left - 1'b1;
                if (cont_left == 0)
                begin
                    produced  = 1'b1;
                    res.cp    = acc_value;
                    acc_value = '0;
                end
            end
        end
        else
        begin
            while (ones < 8 && b[7-ones])
                ones++;
            produced = 1'b1;
            if (ones > 4)
            begin
                res.cp = Replacement;
                res.st = ST_INVALID;
            end
            else if (ones == 0)
                res.cp = cp_t'(b[6:0]);
            else if (ones == 1)
                res.cp = cp_t'(b[5:0]);
            else
            begin
                produced  = 1'b0;
                acc_value = cp_t'(int'(b) & ((1 << (7 - ones)) - 1));
                cont_left = pend_t'(ones - 1);
            end
        end
    endfunction

    task automatic push_byte(input byte_t b, input bit drain = 1'b0);
        byte_item_t it;
        it.data  = b;
        it.gap   = tx_calm ? 0 : $urandom_range(0, 8);
        it.drain = drain;
        byte_q.push_back(it);
        queued_cnt++;
    endtask

    // mostly well-formed sequences with random payload, some broken, some noise
    task automatic push_seq();
        int    kind;
        int    n;
        int    cut;
        byte_t lead;
        kind = $urandom_range(0, 99);
        if (kind < 10)
            push_byte(byte_t'($urandom_range(0, 255)));
        else if (kind < 14)
            push_byte(byte_t'($urandom_range(8'hF8, 8'hFF)));
        else if (kind < 30)
            push_byte(byte_t'($urandom_range(0, 127)));
        else
        begin
            n = $urandom_range(1, 3);
            case (n)
                1:       lead = {3'b110, 5'($urandom)};
                2:       lead = {4'b1110, 4'($urandom)};
                default: lead = {5'b11110, 3'($urandom)};
            endcase
            cut = (kind < 42) ? $urandom_range(0, n - 1) : n;
            push_byte(lead);
            for (int i = 0; i < cut; i++)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_byte({2'b11, 6'($urandom)});
                else
                    push_byte({2'b10, 6'($urandom)});
            end
            if (cut < n)
                push_byte(byte_t'($urandom_range(0, 127)));
        end
    endtask

    task automatic wait_sent();
        while (byte_q.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                tx_wait = cur_gap;
            if (in_valid && !in_taken)
                ; // hold until the transfer
            else if (tx_wait > 0)
            begin
                tx_wait--;
                in_valid <= 1'b0;
            end
            else if (byte_q.size() != 0 && !(byte_q[0].drain && decoded_q.size() != 0))
            begin
                tx_item  = byte_q.pop_front();
                cur_gap  = tx_item.gap;
                in_byte  <= tx_item.data;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // monitor: predict on input transfers, check on output transfers
    always @(posedge clk)
    begin
        in_taken  = rst_n && in_valid && in_ready;
        out_taken = rst_n && out_valid && out_ready;
        if (in_taken)
        begin
            decode_byte(in_byte, has_res, exp_res);
            if (has_res)
                decoded_q.push_back(exp_res);
        end
        if (out_taken)
        begin
            if (decoded_q.size() == 0)
            begin
                $error("unexpected result: code_point %h status %0d", code_point, status);
                err_cnt++;
            end
            else
            begin
                got_res = decoded_q.pop_front();
                if (code_point !== got_res.cp)
                begin
                    $error("code_point: expected %h, got %h", got_res.cp, code_point);
                    err_cnt++;
                end
                if (status !== got_res.st)
                begin
                    $error("status: expected %0d, got %0d", got_res.st, status);
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, invalid leads, lone continuation leads
        push_byte(8'h00);
        push_byte(8'h7F);
        push_byte(8'h80);
        push_byte(8'hBF);
        push_byte(8'hF8);
        push_byte(8'hFF);
        // two, three and four byte sequences, then the widest code point
        push_byte(8'hC2); push_byte(8'hA9);
        push_byte(8'hE2); push_byte(8'h82); push_byte(8'hAC);
        push_byte(8'hF0); push_byte(8'h9F); push_byte(8'h98); push_byte(8'h80);
        push_byte(8'hF7); push_byte(8'hBF); push_byte(8'hBF); push_byte(8'hBF);
        // broken sequence eats the ascii byte
        push_byte(8'hE2); push_byte(8'h41);
        // lead-like byte taken as continuation
        push_byte(8'hC3); push_byte(8'hC3);
        // overlong zero
        push_byte(8'hC0); push_byte(8'h80);

        while (queued_cnt < 350)
            push_seq();
        wait_sent();

        // back-to-back, no idling on either side
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        while (queued_cnt < 550)
            push_seq();
        wait_sent();

        // receiver blocks for a long stretch while bytes keep coming
        rx_calm     = 1'b0;
        rx_hold_req = 1'b1;
        while (queued_cnt < 700)
            push_seq();
        wait_sent();

        // sender waits for all earlier results before the first byte, then sends with random gaps
        tx_calm = 1'b0;
        push_byte(8'h24, 1'b1);
        while (queued_cnt < 925)
            push_seq();
        wait_sent();

        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (err_cnt == 0 && decoded_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule : tb_utf8_stream_decoder_top

`default_nettype wire
